### sv/rspr_pkg.sv
`timescale 1ns / 1ps
// rspr_pkg: types, codes and helpers shared by the packet receiver modules.
// No dependencies.
package rspr_pkg;

  localparam int BUF_SIZE_DEF = 1024;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 3;
  localparam int IDX_W  = 10;
  localparam int LEN_W  = 10;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] BAD_DIGIT = 8'hFF;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_BODY = 2'd1,
    PH_HIGH = 2'd2,
    PH_LOW  = 2'd3
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE     = 3'd0,
    KIND_ACK      = 3'd1,
    KIND_NACK     = 3'd2,
    KIND_RESTART  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [LEN_W-1:0]  payload_length;
    logic              seq_present;
    logic [BYTE_W-1:0] seq_first;
    logic [BYTE_W-1:0] seq_second;
    logic              last;
  } rspr_result_t;

  // vld: the byte yields a result; ovf: an overflow result follows it
  typedef struct packed {
    logic         vld;
    logic         ovf;
    rspr_result_t res;
  } rspr_emit_t;

  // hex digit value, all ones for a non-hex character
  function automatic logic [BYTE_W-1:0] digit_value(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] v;
    v = BAD_DIGIT;
    if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end
    return v;
  endfunction

endpackage

### sv/rspr_parser.sv
`timescale 1ns / 1ps
// rspr_parser: framing state machine, running checksum and sequence capture.
// Depends on rspr_pkg.
module rspr_parser #(
  parameter int BUF_SIZE = rspr_pkg::BUF_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [rspr_pkg::BYTE_W-1:0] rx_byte,
  input  logic                      step,
  output rspr_pkg::rspr_emit_t      emit
);
  import rspr_pkg::*;

  localparam int CNT_W = $clog2(BUF_SIZE);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUF_SIZE - 1);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] first_r, first_nxt;
  logic [BYTE_W-1:0] second_r, second_nxt;
  logic              colon_r, colon_nxt;
  logic [BYTE_W-1:0] high_r, high_nxt;

  logic [CNT_W-1:0]  cnt_inc;
  logic [BYTE_W-1:0] digit;
  logic [BYTE_W-1:0] expect_sum;
  logic              seq_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      sum_r    <= '0;
      cnt_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
      colon_r  <= 1'b0;
      high_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      colon_r  <= colon_nxt;
      high_r   <= high_nxt;
    end
  end

  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign digit      = digit_value(rx_byte);
  assign expect_sum = high_r + digit;
  assign seq_ok     = (cnt_r >= CNT_W'(3)) && colon_r;

  always_comb begin
    phase_nxt  = phase_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    colon_nxt  = colon_r;
    high_nxt   = high_r;

    emit                    = '0;
    emit.res.kind           = KIND_BYTE;
    emit.res.last           = 1'b1;

    unique case (phase_r)
      PH_WAIT: begin
        if (rx_byte == CH_DOLLAR) begin
          phase_nxt = PH_BODY;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          colon_nxt = 1'b0;
        end
      end
      PH_BODY: begin
        if (rx_byte == CH_DOLLAR) begin
          emit.vld                = 1'b1;
          emit.res.kind           = KIND_RESTART;
          emit.res.payload_length = LEN_W'(cnt_r);
          sum_nxt   = '0;
          cnt_nxt   = '0;
          colon_nxt = 1'b0;
        end else if (rx_byte == CH_HASH) begin
          phase_nxt = PH_HIGH;
        end else begin
          sum_nxt = sum_r + rx_byte;
          cnt_nxt = cnt_inc;
          if (cnt_r == CNT_W'(0)) begin
            first_nxt = rx_byte;
          end else if (cnt_r == CNT_W'(1)) begin
            second_nxt = rx_byte;
          end else if (cnt_r == CNT_W'(2)) begin
            colon_nxt = (rx_byte == CH_COLON);
          end
          emit.vld            = 1'b1;
          emit.res.data_byte  = rx_byte;
          emit.res.byte_index = IDX_W'(cnt_r);
          if (cnt_inc == CNT_LIMIT) begin
            emit.ovf      = 1'b1;
            emit.res.last = 1'b0;
            phase_nxt     = PH_WAIT;
          end
        end
      end
      PH_HIGH: begin
        high_nxt  = {digit[3:0], 4'h0};
        phase_nxt = PH_LOW;
      end
      PH_LOW: begin
        phase_nxt               = PH_WAIT;
        emit.vld                = 1'b1;
        emit.res.payload_length = LEN_W'(cnt_r);
        if (expect_sum == sum_r) begin
          emit.res.kind        = KIND_ACK;
          emit.res.seq_present = seq_ok;
          emit.res.seq_first   = seq_ok ? first_r : '0;
          emit.res.seq_second  = seq_ok ? second_r : '0;
        end else begin
          emit.res.kind = KIND_NACK;
        end
      end
      default: begin
        phase_nxt = PH_WAIT;
      end
    endcase
  end

  a_body_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (cnt_r < CNT_LIMIT))
    else $error("body byte count reached the limit without abandon");

endmodule

### sv/rspr_out_stage.sv
`timescale 1ns / 1ps
// rspr_out_stage: result register with a pending overflow result behind it.
// Depends on rspr_pkg.
module rspr_out_stage #(
  parameter int BUF_SIZE = rspr_pkg::BUF_SIZE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rspr_pkg::rspr_emit_t   emit,
  input  logic                   load,
  output logic                   take,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rspr_pkg::rspr_result_t res
);
  import rspr_pkg::*;

  logic         vld_r;
  logic         ovf_pend_r;
  rspr_result_t res_r;
  rspr_result_t ovf_res;

  always_comb begin
    ovf_res                = '0;
    ovf_res.kind           = KIND_OVERFLOW;
    ovf_res.payload_length = LEN_W'(BUF_SIZE - 1);
    ovf_res.last           = 1'b1;
  end

  assign take      = !vld_r || (out_ready && !ovf_pend_r);
  assign out_valid = vld_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      ovf_pend_r <= 1'b0;
    end else if (load) begin
      vld_r      <= 1'b1;
      ovf_pend_r <= emit.ovf;
    end else if (vld_r && out_ready) begin
      vld_r      <= ovf_pend_r;
      ovf_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= emit.res;
    end else if (vld_r && out_ready && ovf_pend_r) begin
      res_r <= ovf_res;
    end
  end

  a_pend_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_pend_r |-> vld_r)
    else $error("overflow pending with no result held");

  a_pend_behind_byte: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_pend_r |-> (res_r.kind == KIND_BYTE && !res_r.last))
    else $error("overflow pending behind a non-payload result");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> take)
    else $error("result register overwritten");

endmodule

### sv/rsp_packet_receiver.sv
`timescale 1ns / 1ps
// rsp_packet_receiver: top level, input register feeding the parser and result register.
// Depends on rspr_pkg, rspr_parser and rspr_out_stage.
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  input   | in_valid, in_ready, in_rx_byte  | in
//  result  | out_valid, out_ready, out_*     | out
//
// One byte is taken per cycle unless the result stalls; input and result are registered.
// A byte that ends a full buffer yields two transactions, the second one
// once the first has been accepted on the result channel.
// A stalled result keeps one byte waiting in the input register.
// Synchronous active-low reset returns the receiver to waiting for a start byte.
module rsp_packet_receiver #(
  parameter int BUF_SIZE = rspr_pkg::BUF_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rspr_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rspr_pkg::KIND_W-1:0] out_kind,
  output logic [rspr_pkg::BYTE_W-1:0] out_data_byte,
  output logic [rspr_pkg::IDX_W-1:0]  out_byte_index,
  output logic [rspr_pkg::LEN_W-1:0]  out_payload_length,
  output logic                        out_seq_present,
  output logic [rspr_pkg::BYTE_W-1:0] out_seq_first,
  output logic [rspr_pkg::BYTE_W-1:0] out_seq_second,
  output logic                        out_last
);
  import rspr_pkg::*;

  logic [BYTE_W-1:0] byte_r;
  logic              vld_r;
  logic              advance;
  logic              take;
  rspr_emit_t        emit;
  rspr_result_t      res;

  assign advance  = vld_r && (!emit.vld || take);
  assign in_ready = !vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (advance) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  rspr_parser #(
    .BUF_SIZE(BUF_SIZE)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .rx_byte(byte_r),
    .step   (advance),
    .emit   (emit)
  );

  rspr_out_stage #(
    .BUF_SIZE(BUF_SIZE)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .emit     (emit),
    .load     (advance && emit.vld),
    .take     (take),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res      (res)
  );

  assign out_kind           = res.kind;
  assign out_data_byte      = res.data_byte;
  assign out_byte_index     = res.byte_index;
  assign out_payload_length = res.payload_length;
  assign out_seq_present    = res.seq_present;
  assign out_seq_first      = res.seq_first;
  assign out_seq_second     = res.seq_second;
  assign out_last           = res.last;

  a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !advance) |=> (vld_r && $stable(byte_r)))
    else $error("waiting input byte lost");

endmodule
